FILE: rtl/ntp_response_checker_core_assert.svh
// Assertion macros used by the SNTP reply checker job queue.
`ifndef NTP_RESPONSE_CHECKER_CORE_ASSERT_SVH
`define NTP_RESPONSE_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define NTPRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ntprc assertion failed");
`define NTPRC_ASSERT_NEXT(lbl, clk, rst, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("ntprc assertion failed");
`else
`define NTPRC_ASSERT(lbl, clk, rst, prop)
`define NTPRC_ASSERT_NEXT(lbl, clk, rst, cause, effect)
`endif

`endif

FILE: rtl/ntprc_pkg.sv
// Types and constants for the SNTP reply checker.
`default_nettype none
package ntprc_pkg;

  localparam logic [1:0] ACT_ARM  = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [5:0] PACKET_BYTES = 6'd48;
  localparam logic [5:0] POS_HEADER   = 6'd0;
  localparam logic [5:0] POS_STRATUM  = 6'd1;
  localparam logic [5:0] NONCE_FIRST  = 6'd24;
  localparam logic [5:0] NONCE_END    = 6'd32;
  localparam logic [5:0] SECS_FIRST   = 6'd40;
  localparam logic [5:0] FRAC_FIRST   = 6'd44;

  localparam logic [2:0] VER_MIN     = 3'd3;
  localparam logic [2:0] VER_MAX     = 3'd4;
  localparam logic [2:0] MODE_SERVER = 3'd4;
  localparam logic [1:0] LEAP_ALARM  = 2'd3;
  localparam logic [7:0] STRATUM_MAX = 8'd15;

  localparam logic [31:0] UNIX_OFFSET = 32'd2208988800;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;

  localparam int EPOCH_W = 44;
  localparam int PROD_W  = 42;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_UNSYNC      = 3'd2,
    ST_IMPLAUSIBLE = 3'd3,
    ST_TIMEOUT     = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] request_nonce;
    logic [63:0] now_ms;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [EPOCH_W-1:0]  epoch_ms;
    logic [31:0]         round_trip_ms;
    logic [63:0]         local_ms;
  } result_t;

  // Finished reply or timeout handed from the parser to the time math.
  typedef struct packed {
    status_t     status;
    logic [31:0] seconds;
    logic [31:0] fraction;
    logic [31:0] round_trip;
    logic [63:0] local_time;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/ntprc_front.sv
// Front end: probe state, per-byte reply parsing, timeout detection.
`default_nettype none
module ntprc_front
  import ntprc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire item_t       item,
  input  wire logic [31:0] timeout_ms,
  output logic             push,
  output job_t             job
);

  logic        probe_waiting;
  logic [63:0] nonce_store;
  logic [63:0] start_time;
  logic [5:0]  byte_count;
  logic        header_bad;
  logic        leap_alarm;
  logic        nonce_mismatch;
  logic [31:0] transmit_seconds;
  logic [31:0] transmit_fraction;

  logic [5:0]  byte_count_next;
  logic        header_bad_next;
  logic        leap_alarm_next;
  logic        nonce_mismatch_next;
  logic [31:0] transmit_seconds_next;
  logic [31:0] transmit_fraction_next;

  logic        take_byte;
  logic        reply_done;
  logic        timed_out;
  logic [63:0] elapsed;

  always_comb begin
    logic [5:0] pos;
    logic [7:0] b;
    logic [2:0] ver;
    logic [2:0] mode;
    pos  = byte_count;
    b    = item.data_byte;
    ver  = b[5:3];
    mode = b[2:0];
    byte_count_next        = byte_count;
    header_bad_next        = header_bad;
    leap_alarm_next        = leap_alarm;
    nonce_mismatch_next    = nonce_mismatch;
    transmit_seconds_next  = transmit_seconds;
    transmit_fraction_next = transmit_fraction;
    if (pos < PACKET_BYTES) begin
      byte_count_next = pos + 6'd1;
      if (pos == POS_HEADER) begin
        if (ver < VER_MIN || ver > VER_MAX || mode != MODE_SERVER) header_bad_next = 1'b1;
        leap_alarm_next = (b[7:6] == LEAP_ALARM);
      end else if (pos == POS_STRATUM) begin
        if (b == 8'd0 || b > STRATUM_MAX) header_bad_next = 1'b1;
      end else if (pos >= NONCE_FIRST && pos < NONCE_END) begin
        // nonce echoed most significant byte first
        if (nonce_store[{~pos[2:0], 3'b000} +: 8] != b) nonce_mismatch_next = 1'b1;
      end else if (pos >= SECS_FIRST && pos < FRAC_FIRST) begin
        transmit_seconds_next = {transmit_seconds[23:0], b};
      end else if (pos >= FRAC_FIRST) begin
        transmit_fraction_next = {transmit_fraction[23:0], b};
      end
    end
  end

  assign elapsed    = item.now_ms - start_time;
  assign take_byte  = accept && probe_waiting && (item.action == ACT_BYTE);
  assign reply_done = take_byte && item.last_byte;
  assign timed_out  = accept && probe_waiting && (item.action == ACT_TICK) &&
                      (elapsed >= {32'd0, timeout_ms});
  assign push       = reply_done || timed_out;

  always_comb begin
    job.seconds    = transmit_seconds_next;
    job.fraction   = transmit_fraction_next;
    job.round_trip = elapsed[31:0];
    job.local_time = item.now_ms;
    priority if (byte_count_next < PACKET_BYTES || header_bad_next) begin
      job.status = ST_INVALID;
    end else if (leap_alarm_next) begin
      job.status = ST_UNSYNC;
    end else if (nonce_mismatch_next) begin
      job.status = ST_INVALID;
    end else begin
      job.status = ST_OK;
    end
    if (timed_out) begin
      job.status     = ST_TIMEOUT;
      job.round_trip = 32'd0;
      job.local_time = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_waiting     <= 1'b0;
      nonce_store       <= 64'd0;
      start_time        <= 64'd0;
      byte_count        <= 6'd0;
      header_bad        <= 1'b0;
      leap_alarm        <= 1'b0;
      nonce_mismatch    <= 1'b0;
      transmit_seconds  <= 32'd0;
      transmit_fraction <= 32'd0;
    end else if (accept && item.action == ACT_ARM) begin
      probe_waiting     <= 1'b1;
      nonce_store       <= item.request_nonce;
      start_time        <= item.now_ms;
      byte_count        <= 6'd0;
      header_bad        <= 1'b0;
      leap_alarm        <= 1'b0;
      nonce_mismatch    <= 1'b0;
      transmit_seconds  <= 32'd0;
      transmit_fraction <= 32'd0;
    end else if (push) begin
      probe_waiting     <= 1'b0;
      byte_count        <= 6'd0;
      header_bad        <= 1'b0;
      leap_alarm        <= 1'b0;
      nonce_mismatch    <= 1'b0;
      transmit_seconds  <= 32'd0;
      transmit_fraction <= 32'd0;
    end else if (take_byte) begin
      byte_count        <= byte_count_next;
      header_bad        <= header_bad_next;
      leap_alarm        <= leap_alarm_next;
      nonce_mismatch    <= nonce_mismatch_next;
      transmit_seconds  <= transmit_seconds_next;
      transmit_fraction <= transmit_fraction_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ntprc_queue.sv
// Small job queue between the reply parser and the time math.
`default_nettype none
`include "ntp_response_checker_core_assert.svh"
module ntprc_queue
  import ntprc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == CW'(0));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `NTPRC_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `NTPRC_ASSERT(a_no_overflow, clk, rst, !(push && full))
  `NTPRC_ASSERT(a_no_underflow, clk, rst, !(pop && empty))
  `NTPRC_ASSERT_NEXT(a_drain_last, clk, rst, pop && !push && (count == CW'(1)), empty)

endmodule
`default_nettype wire

FILE: rtl/ntprc_back.sv
// Back end: NTP to Unix millisecond conversion, bounds check, result register.
`default_nettype none
module ntprc_back
  import ntprc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               empty,
  input  wire job_t               head,
  output logic                    pop,
  input  wire logic [EPOCH_W-1:0] min_epoch_ms,
  input  wire logic [EPOCH_W-1:0] max_epoch_ms,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output result_t                 result
);

  logic advance;

  logic              s1_valid;
  job_t              s1_job;
  logic [31:0]       s1_delta;
  logic [PROD_W-1:0] s1_frac_prod;

  logic              s2_valid;
  job_t              s2_job;
  logic [PROD_W-1:0] s2_sec_ms;
  logic [9:0]        s2_frac_ms;

  logic               s3_valid;
  job_t               s3_job;
  logic [EPOCH_W-1:0] s3_epoch;

  logic    in_bounds;
  status_t final_status;

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && !empty;

  assign in_bounds = (s3_epoch >= min_epoch_ms) && (s3_epoch <= max_epoch_ms);

  always_comb begin
    final_status = s3_job.status;
    if (s3_job.status == ST_OK && !in_bounds) final_status = ST_IMPLAUSIBLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // seconds before the Unix offset belong to era 1; the 32-bit wrap adds 2^32
      s1_job       <= head;
      s1_delta     <= head.seconds - UNIX_OFFSET;
      s1_frac_prod <= PROD_W'(head.fraction) * PROD_W'(MS_PER_S);

      s2_job     <= s1_job;
      s2_sec_ms  <= PROD_W'(s1_delta) * PROD_W'(MS_PER_S);
      s2_frac_ms <= s1_frac_prod[PROD_W-1:32];

      s3_job   <= s2_job;
      s3_epoch <= EPOCH_W'(s2_sec_ms) + EPOCH_W'(s2_frac_ms) +
                  EPOCH_W'(s2_job.round_trip[31:1]);

      result.status        <= final_status;
      result.epoch_ms      <= (final_status == ST_OK) ? s3_epoch : '0;
      result.round_trip_ms <= s3_job.round_trip;
      result.local_ms      <= s3_job.local_time;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ntp_response_checker_core.sv
// SNTP reply checker: arm a probe, stream a 48-byte reply, get status and Unix time.
// Input channel (item_valid/item_stall/item): each transaction is an arm, a reply
// byte or a time tick. Arm stores the request nonce and start time; reply bytes
// are checked as they arrive; the byte marked last_byte closes the reply.
// Output channel (result_valid/result_stall/result): one transaction per closed
// reply and per tick that finds the timeout expired; nothing for other items.
// Throughput: one input transaction per cycle while item_stall is low. A result passes
// through the queue write, subtract and fraction multiply, seconds multiply, sum,
// and bounds check into the output register.
// When the receiver stalls, results back up through the conversion stages into a
// QUEUE_DEPTH job queue; item_stall rises only when that queue is full.
// Reset (rst, synchronous) leaves the probe idle, clears the pipeline and loads
// timeout_ms = 1000, min_epoch_ms = 0, max_epoch_ms = 2^44-1.
// Registers sit on the APB port at byte addresses 0, 8 and 16, 64-bit data;
// write them only while no transaction is in flight.
`default_nettype none
module ntp_response_checker_core
  import ntprc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_MIN_EPOCH = 2'd1;
  localparam logic [1:0] REG_MAX_EPOCH = 2'd2;

  logic [31:0]        timeout_ms;
  logic [EPOCH_W-1:0] min_epoch_ms;
  logic [EPOCH_W-1:0] max_epoch_ms;

  logic cfg_write;
  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms   <= 32'd1000;
      min_epoch_ms <= '0;
      max_epoch_ms <= '1;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_TIMEOUT:   timeout_ms   <= pwdata[31:0];
        REG_MIN_EPOCH: min_epoch_ms <= pwdata[EPOCH_W-1:0];
        REG_MAX_EPOCH: max_epoch_ms <= pwdata[EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_TIMEOUT:   prdata = {32'd0, timeout_ms};
      REG_MIN_EPOCH: prdata = 64'(min_epoch_ms);
      REG_MAX_EPOCH: prdata = 64'(max_epoch_ms);
      default:       prdata = 64'd0;
    endcase
  end

  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  ntprc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .timeout_ms (timeout_ms),
    .push       (push),
    .job        (push_job)
  );

  ntprc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  ntprc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .min_epoch_ms (min_epoch_ms),
    .max_epoch_ms (max_epoch_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
